@@ sv/ebalu_pkg.sv @@
`default_nettype none
package ebalu_pkg;

    // Operation codes
    typedef logic [3:0] t_mode;

    localparam t_mode MODE_ADD   = 4'd0;
    localparam t_mode MODE_ADC   = 4'd1;
    localparam t_mode MODE_SUB   = 4'd2;
    localparam t_mode MODE_SBC   = 4'd3;
    localparam t_mode MODE_AND   = 4'd4;
    localparam t_mode MODE_OR    = 4'd5;
    localparam t_mode MODE_XOR   = 4'd6;
    localparam t_mode MODE_CP    = 4'd7;
    localparam t_mode MODE_INC8  = 4'd8;
    localparam t_mode MODE_DEC8  = 4'd9;
    localparam t_mode MODE_ADD16 = 4'd10;
    localparam t_mode MODE_ADDSP = 4'd11;
    localparam t_mode MODE_INC16 = 4'd12;
    localparam t_mode MODE_DEC16 = 4'd13;

    // Flag word, same bit order as the ports: Z N H C
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

endpackage
`default_nettype wire

@@ sv/eight_bit_cpu_alu_with_flags.sv @@
// An accepted item passes the input register, then the result register, before o_valid rises.
// Throughput: one item per cycle; busy stays low, set by the single ALU pass.
// The result strobe o_valid is high for exactly one cycle per item.
// Reset (synchronous, active low) clears the valid bits; no item is in flight.
`default_nettype none
module eight_bit_cpu_alu_with_flags (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [3:0]  i_mode,
    input  wire logic [15:0] i_operand_a,
    input  wire logic [15:0] i_operand_b,
    input  wire logic [3:0]  i_flags_in,
    output logic            o_valid,
    output logic [15:0]     o_result_value,
    output logic [3:0]      o_flags_out
);
    import ebalu_pkg::*;

    logic        r_in_valid;
    t_mode       r_mode;
    logic [15:0] r_operand_a;
    logic [15:0] r_operand_b;
    t_flags      r_flags_in;

    logic [15:0] n_result;
    t_flags      n_flags;

    logic        r_out_valid;
    logic [15:0] r_result;
    t_flags      r_flags_out;

    // never stalls
    assign busy = 1'b0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        if (start & ~busy) begin
            r_mode      <= i_mode;
            r_operand_a <= i_operand_a;
            r_operand_b <= i_operand_b;
            r_flags_in  <= i_flags_in;
        end
    end

    ebalu_core u_core (
        .i_mode      (r_mode),
        .i_operand_a (r_operand_a),
        .i_operand_b (r_operand_b),
        .i_flags     (r_flags_in),
        .o_result    (n_result),
        .o_flags     (n_flags)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_result    <= n_result;
            r_flags_out <= n_flags;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_result;
    assign o_flags_out    = r_flags_out;

`ifndef SYNTH
    // every accepted item gives one strobe, after the input and result registers
    a_accept_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted item produced no result");

    // no strobe without an item in the input register
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |=> !o_valid)
        else $error("result strobe without an item");

    // compare passes A through untouched
    a_cp_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_mode == MODE_CP) |=> (o_result_value == $past(r_operand_a)))
        else $error("compare altered operand A");

    // 16-bit inc/dec leave every flag alone
    a_inc16_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_mode == MODE_INC16 || r_mode == MODE_DEC16))
        |=> (o_flags_out == $past(r_flags_in)))
        else $error("16-bit inc/dec changed flags");
`endif

endmodule
`default_nettype wire

@@ sv/ebalu_core.sv @@
`default_nettype none
module ebalu_core (
    input  wire ebalu_pkg::t_mode  i_mode,
    input  wire logic [15:0]       i_operand_a,
    input  wire logic [15:0]       i_operand_b,
    input  wire ebalu_pkg::t_flags i_flags,
    output logic [15:0]            o_result,
    output ebalu_pkg::t_flags      o_flags
);
    import ebalu_pkg::*;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cy_add;
    logic        cy_sub;
    logic [8:0]  sum9;
    logic [4:0]  sum_lo;
    logic [8:0]  diff9;
    logic [4:0]  diff_lo;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] sum17;
    logic [12:0] sum_lo12;
    logic [15:0] offset;
    logic [15:0] sp_sum;
    logic [15:0] sp_carry;

    assign a8 = i_operand_a[7:0];
    assign b8 = i_operand_b[7:0];

    // carry in only for the with-carry forms
    assign cy_add = (i_mode == MODE_ADC) ? i_flags.c : 1'b0;
    assign cy_sub = (i_mode == MODE_SBC) ? i_flags.c : 1'b0;

    // 8-bit add, half carry from the nibble sum
    assign sum9   = {1'b0, a8} + {1'b0, b8} + {8'd0, cy_add};
    assign sum_lo = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cy_add};

    // 8-bit subtract, top bit of each difference is the borrow
    assign diff9   = {1'b0, a8} - {1'b0, b8} - {8'd0, cy_sub};
    assign diff_lo = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cy_sub};

    assign inc8 = a8 + 8'd1;
    assign dec8 = a8 - 8'd1;

    // HL add, half carry out of bit 11
    assign sum17    = {1'b0, i_operand_a} + {1'b0, i_operand_b};
    assign sum_lo12 = {1'b0, i_operand_a[11:0]} + {1'b0, i_operand_b[11:0]};

    // SP plus signed byte; carries recovered from a ^ b ^ sum
    assign offset   = {{8{b8[7]}}, b8};
    assign sp_sum   = i_operand_a + offset;
    assign sp_carry = i_operand_a ^ offset ^ sp_sum;

    // result and flag selection
    always_comb begin
        o_result = i_operand_a;
        o_flags  = i_flags;
        unique case (i_mode)
            MODE_ADD, MODE_ADC: begin
                o_result = {8'd0, sum9[7:0]};
                o_flags  = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: sum_lo[4], c: sum9[8]};
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
                o_result = (i_mode == MODE_CP) ? i_operand_a : {8'd0, diff9[7:0]};
                o_flags  = '{z: (diff9[7:0] == 8'd0), n: 1'b1, h: diff_lo[4], c: diff9[8]};
            end
            MODE_AND: begin
                o_result = {8'd0, a8 & b8};
                o_flags  = '{z: ((a8 & b8) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            MODE_OR: begin
                o_result = {8'd0, a8 | b8};
                o_flags  = '{z: ((a8 | b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            MODE_XOR: begin
                o_result = {8'd0, a8 ^ b8};
                o_flags  = '{z: ((a8 ^ b8) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            MODE_INC8: begin
                o_result = {8'd0, inc8};
                o_flags  = '{z: (inc8 == 8'd0), n: 1'b0, h: (a8[3:0] == 4'hF),
                             c: i_flags.c};
            end
            MODE_DEC8: begin
                o_result = {8'd0, dec8};
                o_flags  = '{z: (dec8 == 8'd0), n: 1'b1, h: (a8[3:0] == 4'h0),
                             c: i_flags.c};
            end
            MODE_ADD16: begin
                o_result = sum17[15:0];
                o_flags  = '{z: i_flags.z, n: 1'b0, h: sum_lo12[12], c: sum17[16]};
            end
            MODE_ADDSP: begin
                o_result = sp_sum;
                o_flags  = '{z: 1'b0, n: 1'b0, h: sp_carry[4], c: sp_carry[8]};
            end
            MODE_INC16: begin
                o_result = i_operand_a + 16'd1;
            end
            MODE_DEC16: begin
                o_result = i_operand_a - 16'd1;
            end
            default: begin
                // unassigned codes pass A and the flags through
                o_result = i_operand_a;
                o_flags  = i_flags;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import ebalu_pkg::*;

    // Codes left unassigned by the block, passed through as no-ops
    localparam t_mode MODE_SPARE_LO = 4'd14;
    localparam t_mode MODE_SPARE_HI = 4'd15;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [15:0] value;
        t_flags      flags;
    } t_alu_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_mode       i_mode = MODE_ADD;
    logic [15:0] i_operand_a = 16'h0000;
    logic [15:0] i_operand_b = 16'h0000;
    logic [3:0]  i_flags_in = 4'h0;
    logic        o_valid;
    logic [15:0] o_result_value;
    logic [3:0]  o_flags_out;

    t_alu_out    alu_expected[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          gaps_enabled = 1'b0;

    eight_bit_cpu_alu_with_flags uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .i_flags_in     (i_flags_in),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_flags_out    (o_flags_out)
    );

    always #4 i_clk = ~i_clk;

    // Expected value and flags of one ALU operation
    function automatic t_alu_out compute_alu(t_mode mode, logic [15:0] a16,
                                             logic [15:0] b16, t_flags fin);
        logic [7:0]  a;
        logic [7:0]  b;
        logic        cy;
        logic [8:0]  sum9;
        logic [4:0]  nib;
        logic [16:0] sum17;
        logic [12:0] sum13;
        logic [15:0] offset;
        logic [15:0] carries;
        t_alu_out    r;
        a = a16[7:0];
        b = b16[7:0];
        r.value = a16;
        r.flags = fin;
        case (mode)
            MODE_ADD, MODE_ADC: begin
                cy   = (mode == MODE_ADC) ? fin.c : 1'b0;
                sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
                nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
                r.value   = {8'h00, sum9[7:0]};
                r.flags.z = (sum9[7:0] == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = nib[4];
                r.flags.c = sum9[8];
            end
            MODE_SUB, MODE_SBC, MODE_CP: begin
                // borrow out of bit 3 and bit 7
                cy   = (mode == MODE_SBC) ? fin.c : 1'b0;
                sum9 = {1'b0, a} - {1'b0, b} - {8'h00, cy};
                nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
                r.value   = (mode == MODE_CP) ? a16 : {8'h00, sum9[7:0]};
                r.flags.z = (sum9[7:0] == 8'h00);
                r.flags.n = 1'b1;
                r.flags.h = nib[4];
                r.flags.c = sum9[8];
            end
            MODE_AND, MODE_OR, MODE_XOR: begin
                if (mode == MODE_AND)
                    r.value = {8'h00, a & b};
                else if (mode == MODE_OR)
                    r.value = {8'h00, a | b};
                else
                    r.value = {8'h00, a ^ b};
                r.flags.z = (r.value[7:0] == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = (mode == MODE_AND);
                r.flags.c = 1'b0;
            end
            MODE_INC8: begin
                r.value   = {8'h00, a + 8'h01};
                r.flags.z = (r.value[7:0] == 8'h00);
                r.flags.n = 1'b0;
                r.flags.h = (a[3:0] == 4'hF);
            end
            MODE_DEC8: begin
                r.value   = {8'h00, a - 8'h01};
                r.flags.z = (r.value[7:0] == 8'h00);
                r.flags.n = 1'b1;
                r.flags.h = (a[3:0] == 4'h0);
            end
            MODE_ADD16: begin
                // Z kept, half carry out of bit 11
                sum17 = {1'b0, a16} + {1'b0, b16};
                sum13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
                r.value   = sum17[15:0];
                r.flags.n = 1'b0;
                r.flags.h = sum13[12];
                r.flags.c = sum17[16];
            end
            MODE_ADDSP: begin
                offset  = {{8{b[7]}}, b};
                r.value = a16 + offset;
                carries = a16 ^ offset ^ r.value;
                r.flags.z = 1'b0;
                r.flags.n = 1'b0;
                r.flags.h = carries[4];
                r.flags.c = carries[8];
            end
            MODE_INC16: r.value = a16 + 16'h0001;
            MODE_DEC16: r.value = a16 - 16'h0001;
            default: ;
        endcase
        return r;
    endfunction

    // Operand with a bias towards carry and borrow corners
    function automatic logic [15:0] pick_operand();
        logic [7:0] hi;
        hi = 8'($urandom);
        case ($urandom_range(0, 11))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return {hi, 8'hFF};
            3:       return {hi, 8'h0F};
            4:       return {hi, 8'h80};
            5:       return {hi, 8'h7F};
            6:       return {hi, 8'h10};
            7:       return 16'h0FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Send one item; returns right after the edge that accepts it
    task automatic send_item(t_mode mode, logic [15:0] a, logic [15:0] b, logic [3:0] f);
        int gap;
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_mode      <= mode;
        i_operand_a <= a;
        i_operand_b <= b;
        i_flags_in  <= f;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
    endtask

    task automatic test_ops_8bit();
        send_item(MODE_ADD,   16'h0000, 16'h0000, 4'b0000);
        send_item(MODE_ADD,   16'h00FF, 16'h0001, 4'b0000);
        send_item(MODE_ADD,   16'h000F, 16'h0001, 4'b1111);
        send_item(MODE_ADC,   16'h007F, 16'h0080, 4'b0001);
        send_item(MODE_ADC,   16'hAB12, 16'hCD34, 4'b1110);
        send_item(MODE_SUB,   16'h0000, 16'h0001, 4'b0000);
        send_item(MODE_SUB,   16'hFF3C, 16'h003C, 4'b0000);
        send_item(MODE_SBC,   16'h0000, 16'h00FF, 4'b0001);
        send_item(MODE_SBC,   16'h0010, 16'h0000, 4'b0001);
        // compare passes the whole of A through
        send_item(MODE_CP,    16'h1234, 16'hFF34, 4'b0000);
        send_item(MODE_AND,   16'hFFFF, 16'hFFFF, 4'b0000);
        send_item(MODE_AND,   16'h000F, 16'h00F0, 4'b1111);
        send_item(MODE_OR,    16'hFF00, 16'hFF00, 4'b1111);
        send_item(MODE_XOR,   16'h00AA, 16'h0055, 4'b0000);
    endtask

    task automatic test_ops_16bit();
        send_item(MODE_INC8,  16'h12FF, 16'hFFFF, 4'b0001);
        send_item(MODE_INC8,  16'h000F, 16'h0000, 4'b0000);
        send_item(MODE_DEC8,  16'hFF00, 16'h0000, 4'b0000);
        send_item(MODE_DEC8,  16'h0001, 16'hFFFF, 4'b1111);
        send_item(MODE_ADD16, 16'hFFFF, 16'h0001, 4'b1111);
        send_item(MODE_ADD16, 16'h0FFF, 16'h0001, 4'b0000);
        send_item(MODE_ADDSP, 16'h00FF, 16'hFF01, 4'b1111);
        send_item(MODE_ADDSP, 16'h0000, 16'h0080, 4'b0000);
        send_item(MODE_INC16, 16'hFFFF, 16'h1234, 4'b1010);
        send_item(MODE_DEC16, 16'h0000, 16'hFFFF, 4'b0101);
    endtask

    task automatic test_spare_modes();
        send_item(MODE_SPARE_LO, 16'hA5C3, 16'h5A3C, 4'b1001);
        send_item(MODE_SPARE_HI, 16'h0000, 16'hFFFF, 4'b0110);
    endtask

    task automatic run_random_items(int count);
        t_mode       mode;
        logic [15:0] a;
        logic [15:0] b;
        repeat (count) begin
            // spare codes only now and then
            if ($urandom_range(0, 15) == 0)
                mode = t_mode'($urandom_range(14, 15));
            else
                mode = t_mode'($urandom_range(0, 13));
            a = pick_operand();
            b = pick_operand();
            if ($urandom_range(0, 7) == 0)
                b = a;
            send_item(mode, a, b, 4'($urandom));
        end
    endtask

    task automatic test_random_with_gaps();
        gaps_enabled = 1'b1;
        run_random_items(1500);
    endtask

    task automatic test_random_back_to_back();
        gaps_enabled = 1'b0;
        run_random_items(500);
    endtask

    // Record accepted items, then compare each strobed result
    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n && start && busy === 1'b0)
            alu_expected.push_back(compute_alu(i_mode, i_operand_a, i_operand_b,
                                               t_flags'(i_flags_in)));
        if (i_rst_n && o_valid === 1'b1) begin
            if (alu_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result %h flags %b", o_result_value, o_flags_out);
            end else begin
                want = alu_expected.pop_front();
                if (o_result_value !== want.value || o_flags_out !== want.flags) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: result %h flags %b, expected %h flags %b",
                                 o_result_value, o_flags_out, want.value, want.flags);
                end
            end
        end
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ops_8bit();
        test_ops_16bit();
        test_spare_modes();
        test_random_with_gaps();
        test_random_back_to_back();
        start <= 1'b0;
        while (alu_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && alu_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
sv/ebalu_pkg.sv
sv/ebalu_core.sv
sv/eight_bit_cpu_alu_with_flags.sv
tb/sv/tb_top.sv
